### rtl/core/qrs_pkg.sv
// Package for the quadratic root solver: result kind codes and solve case codes.
// Has no dependencies; the top level imports it.
package qrs_pkg;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_ONE      = 2'd1;
    localparam logic [1:0] KIND_TWO      = 2'd2;
    localparam logic [1:0] KIND_INFINITE = 2'd3;

    localparam int CASE_BITS = 3;
    localparam logic [CASE_BITS-1:0] CASE_NONE     = 3'd0;
    localparam logic [CASE_BITS-1:0] CASE_INFINITE = 3'd1;
    localparam logic [CASE_BITS-1:0] CASE_LINEAR   = 3'd2;
    localparam logic [CASE_BITS-1:0] CASE_DOUBLE   = 3'd3;
    localparam logic [CASE_BITS-1:0] CASE_TWO      = 3'd4;

    localparam int THR_WIDTH = 16;

endpackage

### rtl/core/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage, rounded to nearest.
// No dependencies; used by quadratic_root_solver.
module qrs_sqrt #(
    parameter int VAL_WIDTH = 66
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [VAL_WIDTH-1:0]     val,
    output logic [VAL_WIDTH/2:0]     root
);
    localparam int RW  = VAL_WIDTH / 2;
    localparam int PW  = 2 * RW;
    localparam int RMW = RW + 3;

    logic [RMW-1:0] rem_reg  [0:RW-1];
    logic [RW-1:0]  root_reg [0:RW-1];
    logic [PW-1:0]  val_reg  [0:RW-1];
    logic [RW:0]    round_reg;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RMW-1:0] rem_prev;
        logic [RW-1:0]  root_prev;
        logic [PW-1:0]  val_prev;
        logic [RMW-1:0] rem_shift;
        logic [RMW-1:0] trial;
        logic           ge;
        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign val_prev  = PW'(val);
        end else begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign val_prev  = val_reg[k-1];
        end
        assign rem_shift = {rem_prev[RMW-3:0], val_prev[PW-1 -: 2]};
        assign trial     = {1'b0, root_prev, 2'b01};
        assign ge        = rem_shift >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? rem_shift - trial : rem_shift;
                root_reg[k] <= {root_prev[RW-2:0], ge};
                val_reg[k]  <= {val_prev[PW-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            round_reg <= {1'b0, root_reg[RW-1]}
                       + (RW+1)'(rem_reg[RW-1] > RMW'(root_reg[RW-1]));
        end
    end

    assign root = round_reg;

endmodule

### rtl/core/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded half up.
// The dividend is shifted left by FRAC_BITS first. No dependencies.
module qrs_div #(
    parameter int NUM_WIDTH = 34,
    parameter int DEN_WIDTH = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [NUM_WIDTH-1:0]               num,
    input  logic [DEN_WIDTH-1:0]               den,
    output logic [NUM_WIDTH+FRAC_BITS:0]       quot
);
    localparam int NDW = NUM_WIDTH + FRAC_BITS;
    localparam int RMW = DEN_WIDTH + 1;

    logic [RMW-1:0]       rem_reg [0:NDW-1];
    logic [NDW-1:0]       q_reg   [0:NDW-1];
    logic [NDW-1:0]       n_reg   [0:NDW-1];
    logic [DEN_WIDTH-1:0] den_reg [0:NDW-1];
    logic [NDW:0]         round_reg;

    for (genvar k = 0; k < NDW; k++) begin : g_stage
        logic [RMW-1:0]       rem_prev;
        logic [NDW-1:0]       q_prev;
        logic [NDW-1:0]       n_prev;
        logic [DEN_WIDTH-1:0] den_prev;
        logic [RMW-1:0]       rem_shift;
        logic                 ge;
        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign q_prev   = '0;
            assign n_prev   = {num, {FRAC_BITS{1'b0}}};
            assign den_prev = den;
        end else begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign n_prev   = n_reg[k-1];
            assign den_prev = den_reg[k-1];
        end
        assign rem_shift = {rem_prev[DEN_WIDTH-1:0], n_prev[NDW-1]};
        assign ge        = rem_shift >= {1'b0, den_prev};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? rem_shift - {1'b0, den_prev} : rem_shift;
                q_reg[k]   <= {q_prev[NDW-2:0], ge};
                n_reg[k]   <= {n_prev[NDW-2:0], 1'b0};
                den_reg[k] <= den_prev;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            round_reg <= {1'b0, q_reg[NDW-1]}
                       + (NDW+1)'({rem_reg[NDW-1][DEN_WIDTH-1:0], 1'b0}
                                  >= {1'b0, den_reg[NDW-1]});
        end
    end

    assign quot = round_reg;

endmodule

### rtl/core/quadratic_root_solver.sv
// Top level of the quadratic root solver: coefficient stages, discriminant,
// square root and two dividers. Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
// Usage: each request on the s_ channel carries the coefficients a, b and c of
// a*x^2+b*x+c in signed fixed point. Each produces one request on the m_
// channel with the root kind, two roots and an overflow flag.
// The cfg channel writes the zero threshold; it is always ready and must only
// be written while no request is in flight.
// Requests pass through the square root pipeline (one root bit per stage) and
// then the divider pipeline (one quotient bit per stage). Throughput is one
// request per cycle while the output is not stalled. When the receiver stalls
// with the output register full, the whole pipeline holds and s_tready drops;
// no request is lost or repeated. Reset clears all valid bits and sets the
// threshold to one.
module quadratic_root_solver #(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // coef_square, coef_linear, coef_const from the lowest bit up
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // first_root, second_root from the lowest bit up
    output logic [((2*COEF_WIDTH+7)/8)*8-1:0]      m_tdata,
    // root_kind, overflow from the lowest bit up
    output logic [2:0]                             m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qrs_pkg::THR_WIDTH-1:0]          cfg_data
);
    import qrs_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int ODW    = ((2*W+7)/8)*8;
    localparam int DW     = 2*W + 2;
    localparam int SW     = W + 2;
    localparam int NUMW   = W + 2;
    localparam int DENW   = W + 1;
    localparam int QW     = NUMW + F + 1;
    localparam int SQ_LAT = W + 2;
    localparam int DV_LAT = NUMW + F + 1;
    localparam int TW     = THR_WIDTH + F;
    localparam int CW     = (DW > TW) ? DW : TW;

    typedef struct packed {
        logic                 valid;
        logic [CASE_BITS-1:0] kind;
        logic                 a_neg;
        logic                 b_neg;
        logic                 b_nz;
        logic                 lin_neg;
        logic [W-1:0]         am;
        logic [W-1:0]         bm;
        logic [W-1:0]         cm;
    } coef_t;

    typedef struct packed {
        logic                 valid;
        logic [CASE_BITS-1:0] kind;
        logic                 neg1;
        logic                 neg2;
    } root_side_t;

    logic [THR_WIDTH-1:0] thr_reg;
    logic                 en;

    coef_t         p1_reg;
    logic [2*W-1:0] bsq_reg, ac_reg;
    coef_t         p2_reg;
    coef_t         p3_reg;
    logic [DW-1:0] d_reg;
    coef_t         sq_side_reg [0:SQ_LAT-1];
    logic [SW-1:0] sq_root;
    root_side_t    p4_reg;
    logic [NUMW-1:0] num1_reg, num2_reg;
    logic [DENW-1:0] den_reg;
    root_side_t    dv_side_reg [0:DV_LAT-1];
    logic [QW-1:0] q1, q2;

    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [W-1:0]  out_r1_reg, out_r2_reg;
    logic          out_ovf_reg;

    logic [W-1:0] in_a, in_b, in_c, thr_w;
    coef_t        p1_next;

    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_WIDTH'(1);
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    assign in_a  = s_tdata[W-1:0];
    assign in_b  = s_tdata[2*W-1:W];
    assign in_c  = s_tdata[3*W-1:2*W];
    assign thr_w = W'(thr_reg);

    always_comb begin
        logic az, bz, cz;
        p1_next.valid   = s_tvalid;
        p1_next.a_neg   = in_a[W-1];
        p1_next.b_neg   = in_b[W-1];
        p1_next.am      = in_a[W-1] ? W'(-in_a) : in_a;
        p1_next.bm      = in_b[W-1] ? W'(-in_b) : in_b;
        p1_next.cm      = in_c[W-1] ? W'(-in_c) : in_c;
        p1_next.b_nz    = in_b != '0;
        p1_next.lin_neg = (in_c[W-1] == in_b[W-1]) && (in_c != '0);
        az = (p1_next.am == '0) || (p1_next.am < thr_w);
        bz = (p1_next.bm == '0) || (p1_next.bm < thr_w);
        cz = (p1_next.cm == '0) || (p1_next.cm < thr_w);
        if (!az) begin
            p1_next.kind = CASE_TWO;
        end else if (!bz) begin
            p1_next.kind = CASE_LINEAR;
        end else if (cz) begin
            p1_next.kind = CASE_INFINITE;
        end else begin
            p1_next.kind = CASE_NONE;
        end
        if (!az && (in_a[W-1] != in_c[W-1]) && (in_c != '0)) begin
            p1_next.lin_neg = 1'b1;
        end else if (!az) begin
            p1_next.lin_neg = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.valid <= 1'b0;
            p2_reg.valid <= 1'b0;
        end else if (en) begin
            p1_reg <= p1_next;
            p2_reg <= p1_reg;
        end
        if (en) begin
            bsq_reg <= p1_reg.bm * p1_reg.bm;
            ac_reg  <= p1_reg.am * p1_reg.cm;
        end
    end

    // In the quadratic case lin_neg marks that a and c differ in sign and c is nonzero.
    always_ff @(posedge aclk) begin
        logic [DW-1:0] d;
        logic [CW-1:0] dcmp, tcmp;
        if (!aresetn) begin
            p3_reg.valid <= 1'b0;
        end else if (en) begin
            p3_reg.valid <= p2_reg.valid;
        end
        if (en) begin
            d = p2_reg.lin_neg ? DW'(bsq_reg) + {ac_reg, 2'b00}
                               : DW'(bsq_reg) - {ac_reg, 2'b00};
            dcmp = CW'(d);
            tcmp = CW'({thr_reg, {F{1'b0}}});
            p3_reg.kind    <= p2_reg.kind;
            p3_reg.a_neg   <= p2_reg.a_neg;
            p3_reg.b_neg   <= p2_reg.b_neg;
            p3_reg.b_nz    <= p2_reg.b_nz;
            p3_reg.lin_neg <= p2_reg.lin_neg;
            p3_reg.am      <= p2_reg.am;
            p3_reg.bm      <= p2_reg.bm;
            p3_reg.cm      <= p2_reg.cm;
            d_reg          <= '0;
            if (p2_reg.kind == CASE_TWO) begin
                if (d[DW-1]) begin
                    p3_reg.kind <= CASE_NONE;
                end else if ((d == '0) || (dcmp < tcmp)) begin
                    p3_reg.kind <= CASE_DOUBLE;
                end else begin
                    d_reg <= d;
                end
            end
        end
    end

    qrs_sqrt #(
        .VAL_WIDTH(DW)
    ) u_sqrt (
        .aclk (aclk),
        .en   (en),
        .val  (d_reg),
        .root (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQ_LAT; i++) begin
                sq_side_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            sq_side_reg[0] <= p3_reg;
            for (int i = 1; i < SQ_LAT; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        coef_t             sd;
        logic [NUMW:0]     nb, n1, n2;
        if (!aresetn) begin
            p4_reg.valid <= 1'b0;
        end else if (en) begin
            p4_reg.valid <= sq_side_reg[SQ_LAT-1].valid;
        end
        if (en) begin
            sd = sq_side_reg[SQ_LAT-1];
            nb = sd.b_neg ? (NUMW+1)'(sd.bm) : (NUMW+1)'(-(NUMW+1)'(sd.bm));
            n1 = nb + (NUMW+1)'(sq_root);
            n2 = nb - (NUMW+1)'(sq_root);
            p4_reg.kind <= sd.kind;
            p4_reg.neg2 <= (n2[NUMW] != sd.a_neg) && (n2 != '0);
            den_reg     <= {sd.am, 1'b0};
            num2_reg    <= n2[NUMW] ? NUMW'(-n2) : NUMW'(n2);
            case (sd.kind)
                CASE_LINEAR: begin
                    num1_reg    <= NUMW'(sd.cm);
                    den_reg     <= DENW'(sd.bm);
                    p4_reg.neg1 <= sd.lin_neg;
                end
                CASE_DOUBLE: begin
                    num1_reg    <= NUMW'(sd.bm);
                    p4_reg.neg1 <= (!sd.b_neg && sd.b_nz) != sd.a_neg;
                end
                default: begin
                    num1_reg    <= n1[NUMW] ? NUMW'(-n1) : NUMW'(n1);
                    p4_reg.neg1 <= (n1[NUMW] != sd.a_neg) && (n1 != '0);
                end
            endcase
        end
    end

    qrs_div #(
        .NUM_WIDTH(NUMW),
        .DEN_WIDTH(DENW),
        .FRAC_BITS(F)
    ) u_div_first (
        .aclk (aclk),
        .en   (en),
        .num  (num1_reg),
        .den  (den_reg),
        .quot (q1)
    );

    qrs_div #(
        .NUM_WIDTH(NUMW),
        .DEN_WIDTH(DENW),
        .FRAC_BITS(F)
    ) u_div_second (
        .aclk (aclk),
        .en   (en),
        .num  (num2_reg),
        .den  (den_reg),
        .quot (q2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DV_LAT; i++) begin
                dv_side_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            dv_side_reg[0] <= p4_reg;
            for (int i = 1; i < DV_LAT; i++) begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    function automatic logic [W:0] make_root(input logic [QW-1:0] q, input logic neg,
                                             input logic [THR_WIDTH-1:0] thr);
        logic [QW-1:0] limit;
        logic [W-1:0]  mag;
        logic          ovf;
        limit = neg ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
        ovf   = 1'b0;
        mag   = W'(q);
        if ((q == '0) || (q < QW'(thr))) begin
            mag = '0;
        end else if (q > limit) begin
            mag = W'(limit);
            ovf = 1'b1;
        end
        return {ovf, neg ? W'(-mag) : mag};
    endfunction

    always_ff @(posedge aclk) begin
        root_side_t sd;
        logic [W:0] r1, r2;
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_side_reg[DV_LAT-1].valid;
        end
        if (en) begin
            sd = dv_side_reg[DV_LAT-1];
            r1 = make_root(q1, sd.neg1, thr_reg);
            r2 = make_root(q2, sd.neg2, thr_reg);
            out_r1_reg  <= '0;
            out_r2_reg  <= '0;
            out_ovf_reg <= 1'b0;
            case (sd.kind)
                CASE_NONE: begin
                    out_kind_reg <= KIND_NONE;
                end
                CASE_INFINITE: begin
                    out_kind_reg <= KIND_INFINITE;
                end
                CASE_LINEAR, CASE_DOUBLE: begin
                    out_kind_reg <= KIND_ONE;
                    out_r1_reg   <= r1[W-1:0];
                    out_ovf_reg  <= r1[W];
                end
                CASE_TWO: begin
                    out_kind_reg <= KIND_TWO;
                    out_r1_reg   <= r1[W-1:0];
                    out_r2_reg   <= r2[W-1:0];
                    out_ovf_reg  <= r1[W] | r2[W];
                end
                default: begin
                    out_kind_reg <= KIND_NONE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ODW'({out_r2_reg, out_r1_reg});
    assign m_tuser  = {out_ovf_reg, out_kind_reg};

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for quadratic_root_solver: a directed table of equations, then random
// coefficient sets, checked against tabled roots or a bit-exact fixed-point
// root predictor. Depends on qrs_pkg and the quadratic_root_solver RTL.
module tb;
    import qrs_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int COEF_WIDTH = 32;
    localparam int LATENCY = 3 * COEF_WIDTH + FRAC_BITS + 10;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 258;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] root_a;
        logic [31:0] root_b;
        logic        ovf;
    } roots_t;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        bit          typed;
        roots_t      want;
    } equation_t;

    typedef enum int {
        MIX_RAW, MIX_SMALL, MIX_FACTORED, MIX_NEAR_ZERO
    } mix_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [THR_WIDTH-1:0] cfg_data;

    logic [15:0] zero_thr;
    roots_t      roots_due[$];
    equation_t   directed[$];
    int          failures;
    int          idle_cycles;
    bit          calm;

    quadratic_root_solver #(
        .FRAC_BITS (FRAC_BITS),
        .COEF_WIDTH(COEF_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit below_thr(logic [127:0] mag);
        return mag == 0 || mag < zero_thr;
    endfunction

    // Returns {overflow, root} for a signed quotient rounded half away from zero.
    function automatic logic [32:0] divide_root(bit neg, logic [127:0] num,
                                                logic [127:0] den);
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] limit;
        bit           sat;
        q = (num << FRAC_BITS) / den;
        r = (num << FRAC_BITS) % den;
        if (2 * r >= den) begin
            q = q + 1;
        end
        if (below_thr(q)) begin
            return 33'd0;
        end
        limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        sat = q > limit;
        if (sat) begin
            q = limit;
        end
        return {sat, neg ? 32'(-q[31:0]) : q[31:0]};
    endfunction

    function automatic logic [127:0] rounded_sqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= v) begin
                r = t;
            end
        end
        if (v - r * r > r) begin
            r = r + 1;
        end
        return r;
    endfunction

    function automatic roots_t solve_roots(logic [31:0] ca, logic [31:0] cb,
                                           logic [31:0] cc);
        logic signed [127:0] a, b, c, am, bm, cm, disc, s, n1, n2;
        logic [32:0] r1, r2;
        roots_t res;
        a = 128'(signed'(ca));
        b = 128'(signed'(cb));
        c = 128'(signed'(cc));
        am = a < 0 ? -a : a;
        bm = b < 0 ? -b : b;
        cm = c < 0 ? -c : c;
        res = '0;
        if (below_thr(am)) begin
            if (below_thr(bm)) begin
                res.kind = below_thr(cm) ? KIND_INFINITE : KIND_NONE;
            end else begin
                r1 = divide_root((c < 0) == (b < 0) && c != 0, cm, bm);
                res.kind = KIND_ONE;
                res.root_a = r1[31:0];
                res.ovf = r1[32];
            end
        end else begin
            disc = bm * bm - 4 * a * c;
            if (disc < 0) begin
                res.kind = KIND_NONE;
            end else if (disc < (128'(zero_thr) << FRAC_BITS) || disc == 0) begin
                r1 = divide_root((b > 0) != (a < 0) && b != 0, bm, 2 * am);
                res.kind = KIND_ONE;
                res.root_a = r1[31:0];
                res.ovf = r1[32];
            end else begin
                s = rounded_sqrt(disc);
                n1 = -b + s;
                n2 = -b - s;
                r1 = divide_root((n1 < 0) != (a < 0) && n1 != 0,
                                 n1 < 0 ? -n1 : n1, 2 * am);
                r2 = divide_root((n2 < 0) != (a < 0) && n2 != 0,
                                 n2 < 0 ? -n2 : n2, 2 * am);
                res.kind = KIND_TWO;
                res.root_a = r1[31:0];
                res.root_b = r2[31:0];
                res.ovf = r1[32] | r2[32];
            end
        end
        return res;
    endfunction

    task automatic send_equation(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 bit typed, roots_t want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {c, b, a};
        do @(posedge aclk); while (!s_tready);
        roots_due.push_back(typed ? want : solve_roots(a, b, c));
        @(negedge aclk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        s_tvalid = 1'b0;
        while (roots_due.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        zero_thr = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] signed_range(int span);
        return 32'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic send_random();
        mix_t        mix;
        logic [31:0] a, b, c;
        int          p, q, k;
        mix = mix_t'($urandom_range(0, 3));
        case (mix)
            MIX_RAW: begin
                a = $urandom;
                b = $urandom;
                c = $urandom;
            end
            MIX_SMALL: begin
                a = signed_range(1 << 19);
                b = signed_range(1 << 20);
                c = signed_range(1 << 20);
            end
            MIX_FACTORED: begin
                p = $urandom_range(0, 16) - 8;
                q = ($urandom_range(0, 3) == 0) ? p : $urandom_range(0, 16) - 8;
                k = $urandom_range(1, 4) * (($urandom_range(0, 1) != 0) ? 1 : -1);
                a = 32'(k << FRAC_BITS);
                b = 32'((-k * (p + q)) << FRAC_BITS);
                c = 32'((k * p * q) << FRAC_BITS);
            end
            default: begin
                a = signed_range(int'(zero_thr) + 2);
                b = ($urandom_range(0, 1) != 0) ? signed_range(int'(zero_thr) + 2)
                                                 : signed_range(1 << 20);
                c = ($urandom_range(0, 1) != 0) ? signed_range(int'(zero_thr) + 2)
                                                 : $urandom;
            end
        endcase
        send_equation(a, b, c, 1'b0, '0);
    endtask

    function automatic equation_t row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                      bit typed = 1'b0, logic [1:0] kind = KIND_NONE,
                                      logic [31:0] r1 = 0, logic [31:0] r2 = 0,
                                      logic ovf = 1'b0);
        equation_t e;
        e.a = a;
        e.b = b;
        e.c = c;
        e.typed = typed;
        e.want = '{kind, r1, r2, ovf};
        return e;
    endfunction

    initial begin
        logic [15:0] thresholds[4];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        zero_thr = 16'd1;
        failures = 0;
        calm = 1'b0;

        directed.push_back(row(0, 0, 0, 1, KIND_INFINITE));
        directed.push_back(row(0, 0, 32'h0001_0000, 1, KIND_NONE));
        directed.push_back(row(0, 32'h0001_0000, 32'hfffe_0000, 1, KIND_ONE, 32'h0002_0000));
        directed.push_back(row(32'h0001_0000, 0, 32'h0001_0000, 1, KIND_NONE));
        directed.push_back(row(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 1, KIND_ONE,
                               32'h0001_0000));
        directed.push_back(row(32'h0001_0000, 0, 32'hfffc_0000, 1, KIND_TWO,
                               32'h0002_0000, 32'hfffe_0000));
        directed.push_back(row(0, 1, 32'h7fff_ffff));
        directed.push_back(row(0, 1, 32'h8000_0000));
        directed.push_back(row(1, 32'h7fff_ffff, 0));
        directed.push_back(row(1, 32'h8000_0000, 0));
        directed.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        directed.push_back(row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        directed.push_back(row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        directed.push_back(row(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
        directed.push_back(row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        directed.push_back(row(32'h0001_0000, 1, 0));
        directed.push_back(row(32'h0001_0000, 32'h0000_0400, 32'h0000_0004));
        directed.push_back(row(32'h0001_0000, 32'h0000_0002, 32'h0000_0001));
        directed.push_back(row(32'hffff_0000, 32'h0003_0000, 32'h0004_0000));
        directed.push_back(row(1, 0, 32'h8000_0000));

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        for (int i = 0; i < directed.size(); i++) begin
            send_equation(directed[i].a, directed[i].b, directed[i].c,
                          directed[i].typed, directed[i].want);
        end

        thresholds = '{16'd0, 16'd65535, 16'($urandom), 16'd1};
        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(thresholds[ph]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                calm = n < 30;
                send_random();
            end
            calm = 1'b0;
        end
        s_tvalid = 1'b0;

        while (roots_due.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (failures == 0) begin
            $display("quadratic_root_solver verification clean");
        end else begin
            $display("quadratic_root_solver verification failed");
        end
        $finish;
    end

    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        roots_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (roots_due.size() == 0) begin
                $error("result request with no equation pending");
                failures++;
            end else begin
                want = roots_due.pop_front();
                if (m_tuser[1:0] !== want.kind) begin
                    $error("root_kind: expected %0d, got %0d", want.kind, m_tuser[1:0]);
                    failures++;
                end
                if (m_tdata[31:0] !== want.root_a) begin
                    $error("first_root: expected %h, got %h", want.root_a, m_tdata[31:0]);
                    failures++;
                end
                if (m_tdata[63:32] !== want.root_b) begin
                    $error("second_root: expected %h, got %h", want.root_b, m_tdata[63:32]);
                    failures++;
                end
                if (m_tuser[2] !== want.ovf) begin
                    $error("overflow: expected %0b, got %0b", want.ovf, m_tuser[2]);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("quadratic_root_solver verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule
